// ===== rtl/mbp_pkg.sv =====
`default_nettype none

package mbp_pkg;

   // Fixed field widths.
   localparam int LenBits   = 5;
   localparam int ValueBits = 20;
   localparam int ByteBits  = 8;
   localparam int CountBits = 24;
   localparam int AccBits   = 32;
   localparam int PosBits   = 6;

   // Fewest free bits that must be available before a code is placed.
   localparam int FillThreshold = 23;

   // Saturation value of the byte counter and reset value of the limit.
   localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

   // Free bit position of an empty accumulator.
   localparam logic [PosBits-1:0] PosEmpty = PosBits'(AccBits);

   // Free bit position gained by emitting one byte.
   localparam logic [PosBits-1:0] PosByte = PosBits'(ByteBits);

   // One input item.
   typedef struct packed {
      logic [LenBits-1:0]   code_length;
      logic [ValueBits-1:0] code_value;
      logic                 flush;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [ByteBits-1:0] out_byte;
      logic                last_of_run;
      logic                overflow;
      logic                range_error;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic emit;
      logic finish;
   } mbp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic more;
      logic out_free;
   } mbp_status_type;

endpackage

`default_nettype wire

// ===== rtl/mbp_ctrl.sv =====
`default_nettype none

module mbp_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  mbp_pkg::mbp_status_type status,
   output mbp_pkg::mbp_cmd_type    cmd
);

   import mbp_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;

   assign req_stall = stall_ff;

   // Sequence one item: capture, emit bytes while required, then place or flush.
   always_comb begin
      state_in    = state_ff;
      stall_in    = stall_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !stall_ff) begin
               cmd.capture = 1'b1;
               stall_in    = 1'b1;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.more) begin
               cmd.emit = status.out_free;
            end else begin
               cmd.finish = 1'b1;
               stall_in   = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            stall_in = 1'b0;
         end
      endcase
   end

   // State and registered stall.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mbp_datapath.sv =====
`default_nettype none

module mbp_datapath #(
   parameter int MAX_CODE_BITS = 20
) (
   input  wire                             clock,
   input  wire                             reset,
   input  mbp_pkg::req_type                req_payload,
   input  wire                             csr_valid,
   input  wire                             csr_ready,
   input  wire [mbp_pkg::CountBits-1:0]    csr_wdata,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output mbp_pkg::rsp_type                rsp_payload,
   input  mbp_pkg::mbp_cmd_type            cmd,
   output mbp_pkg::mbp_status_type         status
);

   import mbp_pkg::*;

   localparam logic [LenBits-1:0] MaxLen = LenBits'(MAX_CODE_BITS);
   localparam logic [PosBits-1:0] Thresh =
      PosBits'((MAX_CODE_BITS > FillThreshold) ? MAX_CODE_BITS : FillThreshold);

   logic [AccBits-1:0]   acc_ff, acc_in;
   logic [PosBits-1:0]   pos_ff, pos_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 err_ff, err_in;
   logic [CountBits-1:0] limit_ff;
   req_type              item_ff;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [PosBits-1:0]   pos_step;
   logic [CountBits-1:0] count_step;
   logic [LenBits-1:0]   len_clamped;
   logic [AccBits-1:0]   value_wide;
   logic [AccBits-1:0]   value_mask;
   logic [PosBits-1:0]   pos_placed;
   logic                 bad_len;
   logic                 bad_value;

   // Emit conditions on the current and the post-byte free position.
   assign pos_step        = pos_ff + PosByte;
   assign status.more     = item_ff.flush ? (pos_ff < PosEmpty) : (pos_ff < Thresh);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Saturating byte count including the byte being emitted.
   assign count_step = (count_ff == CountMax) ? count_ff : count_ff + 1'b1;

   // Code checks and alignment for placement.
   assign bad_len     = item_ff.code_length > MaxLen;
   assign bad_value   = (item_ff.code_value >> item_ff.code_length) != '0;
   assign len_clamped = bad_len ? MaxLen : item_ff.code_length;
   assign value_mask  = ~({AccBits{1'b1}} << len_clamped);
   assign value_wide  = AccBits'(item_ff.code_value) & value_mask;
   assign pos_placed  = pos_ff - PosBits'(len_clamped);

   // Next state of the accumulator, counters and result register.
   always_comb begin
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_in.out_byte    = acc_ff[AccBits-1 -: ByteBits];
         rsp_in.last_of_run = item_ff.flush ? (pos_step >= PosEmpty) : (pos_step >= Thresh);
         rsp_in.overflow    = count_step > limit_ff;
         rsp_in.range_error = err_ff;
         rsp_valid_in       = 1'b1;
         acc_in             = acc_ff << ByteBits;
         pos_in             = pos_step;
         count_in           = count_step;
      end else if (cmd.finish) begin
         if (item_ff.flush) begin
            acc_in = '0;
            pos_in = PosEmpty;
         end else begin
            err_in = err_ff | bad_len | bad_value;
            if (len_clamped != '0) begin
               pos_in = pos_placed;
               acc_in = acc_ff | (value_wide << pos_placed[PosBits-2:0]);
            end
         end
      end
   end

   // Stream state and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pos_ff       <= PosEmpty;
         count_ff     <= '0;
         err_ff       <= 1'b0;
         limit_ff     <= CountMax;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // Captured item and result payload.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/msb_first_bit_packer_unit.sv =====
// MSB-first bit packer.
// Input channel (req_valid, req_stall, req_payload): one code of up to
// MAX_CODE_BITS bits, or a flush. Result channel (rsp_valid, rsp_stall,
// rsp_payload): packed bytes, one per transfer, with last_of_run marking the
// final byte an item causes. An item that causes no byte gives no transfer.
// Configuration channel (csr_valid, csr_ready, csr_wdata): the byte limit
// beyond which overflow is flagged; csr_ready is always high, and the limit
// should be written only while no item is in progress.
// Sequence: an item (0 to 3 bytes, up to 4 on flush) is captured, its bytes
// are emitted one per cycle through the single result register while the
// receiver does not stall, then its code is placed or the flush done. The
// first byte is registered into the result register by the run state.
// Reset (synchronous): accumulator empty, byte count and sticky error clear,
// limit set to its maximum. A stalled receiver holds the result register
// and pauses byte emission; the input stays stalled until the item is done.
`default_nettype none

module msb_first_bit_packer_unit #(
   parameter int MAX_CODE_BITS = 20
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  mbp_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output mbp_pkg::rsp_type             rsp_payload,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [mbp_pkg::CountBits-1:0] csr_wdata
);

   import mbp_pkg::*;

   mbp_cmd_type    cmd;
   mbp_status_type status;

   assign csr_ready = 1'b1;

   // Sequencer.
   mbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Accumulator, counters and result register.
   mbp_datapath #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

   // An accepted item keeps the input stalled in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after item transfer");

   // No result is pending right after reset.
   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With no result pending, no byte is presented in the cycle right after an item transfer.
   a_no_early_byte: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> !rsp_valid)
      else $error("byte presented too early");

endmodule

`default_nettype wire
